// ----- design/grid_stride_decimator_3d_assert.svh -----
// Assertion macros used by the grid stride decimator RTL.
`ifndef GRID_STRIDE_DECIMATOR_3D_ASSERT_SVH
`define GRID_STRIDE_DECIMATOR_3D_ASSERT_SVH

// Clocked assertion, ignored while reset is asserted.
`define GSD3_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define GSD3_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/gsd3_pkg.sv -----
// Package for the grid stride decimator: defaults, config index codes.
`default_nettype none

package gsd3_pkg;

    // Default widths
    localparam int COORD_WIDTH_DEF  = 16;
    localparam int SAMPLE_WIDTH_DEF = 64;

    // Configuration register index width and codes
    localparam int CFG_INDEX_WIDTH = 3;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_SIZE_I    = 3'd0,
        REG_SIZE_J    = 3'd1,
        REG_SIZE_K    = 3'd2,
        REG_STRIDE_I  = 3'd3,
        REG_STRIDE_J  = 3'd4,
        REG_STRIDE_K  = 3'd5,
        REG_KEEP_LAST = 3'd6
    } cfg_reg_t;

endpackage

`default_nettype wire

// ----- design/grid_stride_decimator_3d.sv -----
// Top level of the strided 3-D grid decimator.
`default_nettype none
`include "grid_stride_decimator_3d_assert.svh"

// Takes grid samples in raster order (i fastest, then j, then k) and passes
// on those whose coordinates all sit on the per-axis stride, or, with
// keep_last set, on the last index of an axis. Each kept sample leaves with
// its source coordinates. Counters wrap at the grid end, so successive grids
// stream back to back. Throughput is one sample per cycle: the keep test and
// counter update are combinational logic ahead of the output register, and a
// one-entry skid register behind it lets a request be taken while a result
// is stalled. The input stalls only when both the output and skid registers
// hold results. Write configuration only while the block is idle; counters
// are not cleared by a write.
module grid_stride_decimator_3d #(
    parameter int COORD_WIDTH  = gsd3_pkg::COORD_WIDTH_DEF,
    parameter int SAMPLE_WIDTH = gsd3_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // configuration write port
    input  wire logic                                 cfg_wr_en,
    input  wire logic [gsd3_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [COORD_WIDTH-1:0]               cfg_data,
    // input samples
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [SAMPLE_WIDTH-1:0]              s_sample,
    // kept samples
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [SAMPLE_WIDTH-1:0]                   m_kept_sample,
    output logic [COORD_WIDTH-1:0]                    m_src_i,
    output logic [COORD_WIDTH-1:0]                    m_src_j,
    output logic [COORD_WIDTH-1:0]                    m_src_k
);

    localparam logic [COORD_WIDTH-1:0] ONE  = COORD_WIDTH'(1);
    localparam logic [COORD_WIDTH-1:0] ZERO = '0;

    // Configuration registers
    logic [COORD_WIDTH-1:0] size_i_reg, size_j_reg, size_k_reg;
    logic [COORD_WIDTH-1:0] stride_i_reg, stride_j_reg, stride_k_reg;
    logic                   keep_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_i_reg    <= ONE;
            size_j_reg    <= ONE;
            size_k_reg    <= ONE;
            stride_i_reg  <= ONE;
            stride_j_reg  <= ONE;
            stride_k_reg  <= ONE;
            keep_last_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                gsd3_pkg::REG_SIZE_I:    size_i_reg    <= cfg_data;
                gsd3_pkg::REG_SIZE_J:    size_j_reg    <= cfg_data;
                gsd3_pkg::REG_SIZE_K:    size_k_reg    <= cfg_data;
                gsd3_pkg::REG_STRIDE_I:  stride_i_reg  <= cfg_data;
                gsd3_pkg::REG_STRIDE_J:  stride_j_reg  <= cfg_data;
                gsd3_pkg::REG_STRIDE_K:  stride_k_reg  <= cfg_data;
                gsd3_pkg::REG_KEEP_LAST: keep_last_reg <= cfg_data[0];
                default: ;  // unknown index: write ignored
            endcase
        end
    end

    // Coordinate and stride phase counters
    logic [COORD_WIDTH-1:0] coord_i_reg, coord_j_reg, coord_k_reg;
    logic [COORD_WIDTH-1:0] phase_i_reg, phase_j_reg, phase_k_reg;
    logic [COORD_WIDTH-1:0] coord_i_next, coord_j_next, coord_k_next;
    logic [COORD_WIDTH-1:0] phase_i_next, phase_j_next, phase_k_next;

    // Last index on each axis; size zero wraps to the full counter range
    logic [COORD_WIDTH-1:0] last_i, last_j, last_k;
    logic                   at_last_i, at_last_j, at_last_k;
    logic                   keep_i, keep_j, keep_k, keep;
    logic                   s_accept;

    assign last_i    = size_i_reg - ONE;
    assign last_j    = size_j_reg - ONE;
    assign last_k    = size_k_reg - ONE;
    assign at_last_i = (coord_i_reg == last_i);
    assign at_last_j = (coord_j_reg == last_j);
    assign at_last_k = (coord_k_reg == last_k);

    // Keep test: on the stride, or on the last index with keep_last
    assign keep_i = (phase_i_reg == ZERO) || (keep_last_reg && at_last_i);
    assign keep_j = (phase_j_reg == ZERO) || (keep_last_reg && at_last_j);
    assign keep_k = (phase_k_reg == ZERO) || (keep_last_reg && at_last_k);
    assign keep   = keep_i && keep_j && keep_k;

    assign s_accept = s_valid && s_ready;

    // Counter advance: i every sample, j on i wrap, k on j wrap
    always_comb begin
        coord_i_next = coord_i_reg;
        phase_i_next = phase_i_reg;
        coord_j_next = coord_j_reg;
        phase_j_next = phase_j_reg;
        coord_k_next = coord_k_reg;
        phase_k_next = phase_k_reg;
        if (at_last_i) begin
            coord_i_next = ZERO;
            phase_i_next = ZERO;
            if (at_last_j) begin
                coord_j_next = ZERO;
                phase_j_next = ZERO;
                if (at_last_k) begin
                    coord_k_next = ZERO;
                    phase_k_next = ZERO;
                end else begin
                    coord_k_next = coord_k_reg + ONE;
                    phase_k_next = (phase_k_reg == stride_k_reg - ONE) ? ZERO
                                                                       : phase_k_reg + ONE;
                end
            end else begin
                coord_j_next = coord_j_reg + ONE;
                phase_j_next = (phase_j_reg == stride_j_reg - ONE) ? ZERO
                                                                   : phase_j_reg + ONE;
            end
        end else begin
            coord_i_next = coord_i_reg + ONE;
            phase_i_next = (phase_i_reg == stride_i_reg - ONE) ? ZERO : phase_i_reg + ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coord_i_reg <= ZERO;
            coord_j_reg <= ZERO;
            coord_k_reg <= ZERO;
            phase_i_reg <= ZERO;
            phase_j_reg <= ZERO;
            phase_k_reg <= ZERO;
        end else if (s_accept) begin
            coord_i_reg <= coord_i_next;
            coord_j_reg <= coord_j_next;
            coord_k_reg <= coord_k_next;
            phase_i_reg <= phase_i_next;
            phase_j_reg <= phase_j_next;
            phase_k_reg <= phase_k_next;
        end
    end

    // Output register plus one-entry skid register
    logic                    m_valid_reg, skid_valid_reg;
    logic [SAMPLE_WIDTH-1:0] out_sample_reg, skid_sample_reg;
    logic [COORD_WIDTH-1:0]  out_i_reg, out_j_reg, out_k_reg;
    logic [COORD_WIDTH-1:0]  skid_i_reg, skid_j_reg, skid_k_reg;
    logic                    out_free;
    logic                    push;

    assign out_free = !m_valid_reg || m_ready;
    assign push     = s_accept && keep;

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_free) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (out_free) begin
                m_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_free) begin
                out_sample_reg <= skid_sample_reg;
                out_i_reg      <= skid_i_reg;
                out_j_reg      <= skid_j_reg;
                out_k_reg      <= skid_k_reg;
            end
        end else if (push) begin
            if (out_free) begin
                out_sample_reg <= s_sample;
                out_i_reg      <= coord_i_reg;
                out_j_reg      <= coord_j_reg;
                out_k_reg      <= coord_k_reg;
            end else begin
                skid_sample_reg <= s_sample;
                skid_i_reg      <= coord_i_reg;
                skid_j_reg      <= coord_j_reg;
                skid_k_reg      <= coord_k_reg;
            end
        end
    end

    assign s_ready       = !skid_valid_reg;
    assign m_valid       = m_valid_reg;
    assign m_kept_sample = out_sample_reg;
    assign m_src_i       = out_i_reg;
    assign m_src_j       = out_j_reg;
    assign m_src_k       = out_k_reg;

    // Assertions
    `GSD3_ASSERT(a_skid_behind_out, aclk, aresetn, skid_valid_reg |-> m_valid_reg, "skid holds a result while the output register is empty")
    `GSD3_ASSERT(a_stall_fills_skid, aclk, aresetn, (push && m_valid_reg && !m_ready) |=> skid_valid_reg, "kept sample during output stall did not enter the skid register")
    `GSD3_ASSERT(a_i_wrap, aclk, aresetn, (s_accept && at_last_i) |=> (coord_i_reg == ZERO && phase_i_reg == ZERO), "i counter did not wrap at the last index")
    `GSD3_ASSERT(a_j_holds, aclk, aresetn, (s_accept && !at_last_i) |=> ($stable(coord_j_reg) && $stable(coord_k_reg)), "j or k moved without an i wrap")
    `GSD3_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> (!m_valid_reg && !skid_valid_reg), "result registers not empty after reset")

endmodule

`default_nettype wire
